FILE: sv/scpf_pkg.sv
// Shared types, packet constants and the sequencer program for the servo command framer.
package scpf_pkg;

    // Request kinds carried on the slave tuser.
    localparam logic [1:0] KIND_POS_WRITE  = 2'd0;
    localparam logic [1:0] KIND_MODE_WRITE = 2'd1;
    localparam logic [1:0] KIND_POS_READ   = 2'd2;
    localparam logic [1:0] KIND_UNDEFINED  = 2'd3;

    // Fixed packet bytes.
    localparam logic [7:0] HDR_BYTE      = 8'hFF;
    localparam logic [7:0] LEN_POS_WRITE = 8'h09;
    localparam logic [7:0] LEN_SHORT     = 8'h04;
    localparam logic [7:0] INS_WRITE     = 8'h03;
    localparam logic [7:0] INS_READ      = 8'h02;
    localparam logic [7:0] ADDR_GOAL     = 8'h2A;
    localparam logic [7:0] ADDR_MODE     = 8'h21;
    localparam logic [7:0] ADDR_PRESENT  = 8'h38;
    localparam logic [7:0] READ_COUNT    = 8'h02;

    localparam int PC_W = 5;

    // Program entry points.
    localparam logic [PC_W-1:0] PC_START = 5'd0;
    localparam logic [PC_W-1:0] PC_POS   = 5'd4;
    localparam logic [PC_W-1:0] PC_MODE  = 5'd14;
    localparam logic [PC_W-1:0] PC_READ  = 5'd19;

    typedef enum logic [3:0] {
        SRC_CONST,
        SRC_ID,
        SRC_POS_LO,
        SRC_POS_HI,
        SRC_TIM_LO,
        SRC_TIM_HI,
        SRC_SPD_LO,
        SRC_SPD_HI,
        SRC_MODE,
        SRC_CHK
    } t_src;

    typedef enum logic [1:0] {
        NX_SEQ,
        NX_KIND,
        NX_END
    } t_nxt;

    typedef struct packed {
        t_src       src;
        logic [7:0] konst;
        logic       sum_en;
        logic       last;
        t_nxt       nxt;
    } t_uword;

    function automatic t_uword uw(t_src src, logic [7:0] konst, logic sum_en,
                                  logic last, t_nxt nxt);
        t_uword w;
        w.src    = src;
        w.konst  = konst;
        w.sum_en = sum_en;
        w.last   = last;
        w.nxt    = nxt;
        return w;
    endfunction

    // Control store: one word per emitted byte.
    function automatic t_uword urom(logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            5'd0:    w = uw(SRC_CONST,  HDR_BYTE,      1'b0, 1'b0, NX_SEQ);
            5'd1:    w = uw(SRC_CONST,  HDR_BYTE,      1'b0, 1'b0, NX_SEQ);
            5'd2:    w = uw(SRC_ID,     8'h00,         1'b1, 1'b0, NX_KIND);
            // position write body
            5'd4:    w = uw(SRC_CONST,  LEN_POS_WRITE, 1'b1, 1'b0, NX_SEQ);
            5'd5:    w = uw(SRC_CONST,  INS_WRITE,     1'b1, 1'b0, NX_SEQ);
            5'd6:    w = uw(SRC_CONST,  ADDR_GOAL,     1'b1, 1'b0, NX_SEQ);
            5'd7:    w = uw(SRC_POS_LO, 8'h00,         1'b1, 1'b0, NX_SEQ);
            5'd8:    w = uw(SRC_POS_HI, 8'h00,         1'b1, 1'b0, NX_SEQ);
            5'd9:    w = uw(SRC_TIM_LO, 8'h00,         1'b1, 1'b0, NX_SEQ);
            5'd10:   w = uw(SRC_TIM_HI, 8'h00,         1'b1, 1'b0, NX_SEQ);
            5'd11:   w = uw(SRC_SPD_LO, 8'h00,         1'b1, 1'b0, NX_SEQ);
            5'd12:   w = uw(SRC_SPD_HI, 8'h00,         1'b1, 1'b0, NX_SEQ);
            5'd13:   w = uw(SRC_CHK,    8'h00,         1'b0, 1'b1, NX_END);
            // mode write body
            5'd14:   w = uw(SRC_CONST,  LEN_SHORT,     1'b1, 1'b0, NX_SEQ);
            5'd15:   w = uw(SRC_CONST,  INS_WRITE,     1'b1, 1'b0, NX_SEQ);
            5'd16:   w = uw(SRC_CONST,  ADDR_MODE,     1'b1, 1'b0, NX_SEQ);
            5'd17:   w = uw(SRC_MODE,   8'h00,         1'b1, 1'b0, NX_SEQ);
            5'd18:   w = uw(SRC_CHK,    8'h00,         1'b0, 1'b1, NX_END);
            // position read request body
            5'd19:   w = uw(SRC_CONST,  LEN_SHORT,     1'b1, 1'b0, NX_SEQ);
            5'd20:   w = uw(SRC_CONST,  INS_READ,      1'b1, 1'b0, NX_SEQ);
            5'd21:   w = uw(SRC_CONST,  ADDR_PRESENT,  1'b1, 1'b0, NX_SEQ);
            5'd22:   w = uw(SRC_CONST,  READ_COUNT,    1'b1, 1'b0, NX_SEQ);
            5'd23:   w = uw(SRC_CHK,    8'h00,         1'b0, 1'b1, NX_END);
            default: w = uw(SRC_CHK,    8'h00,         1'b0, 1'b1, NX_END);
        endcase
        return w;
    endfunction

endpackage

FILE: sv/servo_command_packet_framer.sv
// Servo bus instruction packet framer: one request in, its packet bytes out.
//
// Usage: a request arrives on the slave stream. tuser carries the request kind
// (position write, mode write or position read request) and tdata carries the
// servo id, goal position, move time, move speed and mode byte. Once the
// request is taken, the packet leaves on the master stream one byte per
// transfer, header first, with tlast set on the closing checksum byte.
// A position write gives 13 bytes, the other two kinds give 8 bytes each.
// A request of the undefined fourth kind is taken and produces nothing.
//
// Timing: the request is captured into the payload and sequencer registers,
// then the output register presents one byte per cycle while the receiver
// is ready. The sequencer steps through a 24-word control store, one word
// per byte, and handles one request at a time: the slave side is ready
// again once the checksum byte sits in the output register, and the next
// packet's first byte can only follow once the next request is taken.
// A stalled receiver freezes the step counter and output register.
// Reset (synchronous, active low) empties the output register and stops the
// sequencer; no bytes are lost or repeated across stalls.
module servo_command_packet_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] servo_id, [23:8] goal_position, [34:24] move_time,
    // [50:35] move_speed, [58:51] mode_value, [63:59] zero
    input  logic [63:0] s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] tx_byte
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);
    import scpf_pkg::*;

    // Request fields.
    logic [7:0]         w_id;
    logic [15:0]        w_pos;
    logic [10:0]        w_tim;
    logic [15:0]        w_spd;
    logic [7:0]         w_mode;
    logic [15:0]        w_tim_enc;
    logic [15:0]        w_spd_enc;
    logic [10:0]        w_tim_neg;
    logic [15:0]        w_spd_neg;

    // Captured payload.
    logic [7:0]         r_id;
    logic [15:0]        r_pos;
    logic [15:0]        r_tim;
    logic [15:0]        r_spd;
    logic [7:0]         r_mode;
    logic [1:0]         r_kind;

    // Sequencer state.
    logic               r_busy;
    logic [PC_W-1:0]    r_pc;
    logic [7:0]         r_sum;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_last;

    logic               w_in_xfer;
    logic               w_step;
    t_uword             w_uw;
    logic [7:0]         w_byte;
    logic [PC_W-1:0]    n_pc;
    logic [PC_W-1:0]    w_entry;

    assign w_id   = s_axis_tdata[7:0];
    assign w_pos  = s_axis_tdata[23:8];
    assign w_tim  = s_axis_tdata[34:24];
    assign w_spd  = s_axis_tdata[50:35];
    assign w_mode = s_axis_tdata[58:51];

    // Sign-magnitude encoding: magnitude with the sign moved to the top flag bit.
    // The most negative value keeps its own pattern, which already equals the flag.
    assign w_tim_neg = (~w_tim) + 11'd1;
    assign w_spd_neg = (~w_spd) + 16'd1;
    assign w_tim_enc = w_tim[10] ? {5'd0, w_tim_neg | 11'h400} : {5'd0, w_tim};
    assign w_spd_enc = w_spd[15] ? (w_spd_neg | 16'h8000) : w_spd;

    assign s_axis_tready = !r_busy;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_step        = r_busy && (!r_out_valid || m_axis_tready);

    assign w_uw = urom(r_pc);

    always_comb begin
        unique case (w_uw.src)
            SRC_CONST:  w_byte = w_uw.konst;
            SRC_ID:     w_byte = r_id;
            SRC_POS_LO: w_byte = r_pos[7:0];
            SRC_POS_HI: w_byte = r_pos[15:8];
            SRC_TIM_LO: w_byte = r_tim[7:0];
            SRC_TIM_HI: w_byte = r_tim[15:8];
            SRC_SPD_LO: w_byte = r_spd[7:0];
            SRC_SPD_HI: w_byte = r_spd[15:8];
            SRC_MODE:   w_byte = r_mode;
            SRC_CHK:    w_byte = ~r_sum;
            default:    w_byte = 8'h00;
        endcase
    end

    // Dispatch on the request kind after the id byte.
    always_comb begin
        unique case (r_kind)
            KIND_POS_WRITE:  w_entry = PC_POS;
            KIND_MODE_WRITE: w_entry = PC_MODE;
            KIND_POS_READ:   w_entry = PC_READ;
            default:         w_entry = PC_POS;
        endcase
    end

    always_comb begin
        unique case (w_uw.nxt)
            NX_SEQ:  n_pc = r_pc + 5'd1;
            NX_KIND: n_pc = w_entry;
            NX_END:  n_pc = PC_START;
            default: n_pc = PC_START;
        endcase
    end

    // Payload capture; no reset needed.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_id   <= w_id;
            r_pos  <= w_pos;
            r_tim  <= w_tim_enc;
            r_spd  <= w_spd_enc;
            r_mode <= w_mode;
            r_kind <= s_axis_tuser;
        end
    end

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= PC_START;
            r_sum       <= 8'h00;
            r_out_valid <= 1'b0;
            r_out_byte  <= 8'h00;
            r_out_last  <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && !w_step) begin
                r_out_valid <= 1'b0;
            end
            if (w_in_xfer) begin
                // The undefined kind is dropped without output.
                r_busy <= (s_axis_tuser != KIND_UNDEFINED);
                r_pc   <= PC_START;
                r_sum  <= 8'h00;
            end else if (w_step) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= w_byte;
                r_out_last  <= w_uw.last;
                r_pc        <= n_pc;
                if (w_uw.sum_en) begin
                    r_sum <= r_sum + w_byte;
                end
                if (w_uw.nxt == NX_END) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;

endmodule
